### design/mbre_pkg.sv
`default_nettype none
package mbre_pkg;
  localparam int unsigned NUM_MAT = 4;
  localparam int unsigned WORD_BITS = 14;
  localparam int unsigned NUM_REGS = 7;
  localparam logic [1:0] MAT_SAND = 2'd0;
  localparam logic [1:0] MAT_WATER = 2'd1;
  localparam logic [1:0] MAT_GAS = 2'd2;
  localparam logic [1:0] MAT_FIRE = 2'd3;
  localparam logic [2:0] REG_WOOD = 3'd0;
  localparam logic [2:0] REG_SAND = 3'd1;
  localparam logic [2:0] REG_WATER = 3'd2;
  localparam logic [2:0] REG_GAS = 3'd3;
  localparam logic [2:0] REG_FIRE = 3'd4;
  localparam logic [2:0] REG_DESTROY = 3'd5;
  localparam logic [2:0] REG_CHANCE = 3'd6;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_BLOCK = 1'b1;
  localparam logic [1:0] PICK_ALT = 2'd1;
endpackage
`default_nettype wire

### design/mbre_rule_cell.sv
`default_nettype none
// One rule slot of one material pass: tries its rule on the block passing by
// and hands the block, and whether a rule already fired, to the next cell.
module mbre_rule_cell #(
  parameter int unsigned CELL_BITS = 4
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [13:0]               wdata,
  input  wire logic                      in_vld,
  input  wire logic                      in_act,
  input  wire logic                      in_done,
  input  wire logic [4*CELL_BITS-1:0]    in_blk,
  input  wire logic [CELL_BITS-1:0]      mat,
  input  wire logic                      destroy,
  input  wire logic                      want_alt,
  input  wire logic                      rst,
  output logic                           out_vld,
  output logic                           out_act,
  output logic                           out_done,
  output logic [4*CELL_BITS-1:0]         out_blk,
  output logic [13:0]                    rule
);
  import mbre_pkg::*;
  logic [3:0] tp;
  logic ok;
  logic [4*CELL_BITS-1:0] res;
  logic [CELL_BITS-1:0] c;
  logic [CELL_BITS-1:0] rv;

  always_ff @(posedge clk) begin
    if (rst) rule <= '0;
    else if (we) rule <= wdata;
  end

  always_comb begin
    tp = (want_alt && rule[13]) ? rule[11:8] : rule[7:4];
    ok = rule[12];
    res = in_blk;
    rv = '0;
    for (int j = 0; j < 4; j++) begin
      c = in_blk[j*CELL_BITS +: CELL_BITS];
      rv = rule[j] ? mat : '0;
      if (!destroy) begin
        if (c != rv) ok = 1'b0;
        res[j*CELL_BITS +: CELL_BITS] = tp[j] ? mat : '0;
      end else if (rv == '0 && c != mat) begin
        if (c == '0 || c == CELL_BITS'(1))
          res[j*CELL_BITS +: CELL_BITS] = tp[j] ? mat : '0;
      end else if (rv == mat && c == mat) begin
        res[j*CELL_BITS +: CELL_BITS] = tp[j] ? mat : '0;
      end else begin
        ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= in_vld;
    out_act <= in_act;
    if (in_act && !in_done && ok) begin
      out_done <= 1'b1;
      out_blk <= res;
    end else begin
      out_done <= in_done;
      out_blk <= in_blk;
    end
  end
endmodule
`default_nettype wire

### design/mbre_pass.sv
`default_nettype none
// One material pass: presence check at entry, then a chain of rule cells.
module mbre_pass #(
  parameter int unsigned CELL_BITS = 4,
  parameter int unsigned RULES = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [RULES-1:0]       we,
  input  wire logic [13:0]            wdata,
  input  wire logic                   in_vld,
  input  wire logic                   in_en,
  input  wire logic [4*CELL_BITS-1:0] in_blk,
  input  wire logic [CELL_BITS-1:0]   mat,
  input  wire logic                   destroy,
  input  wire logic                   want_alt,
  output logic                        out_vld,
  output logic [4*CELL_BITS-1:0]      out_blk,
  output logic [RULES*14-1:0]         rules
);
  import mbre_pkg::*;
  logic [RULES:0] v, a, d;
  logic [4*CELL_BITS-1:0] b [RULES+1];
  logic pres;

  always_comb begin
    pres = 1'b0;
    for (int j = 0; j < 4; j++)
      if (in_blk[j*CELL_BITS +: CELL_BITS] == mat) pres = 1'b1;
  end
  assign v[0] = in_vld;
  assign a[0] = in_en && pres;
  assign d[0] = 1'b0;
  assign b[0] = in_blk;

  for (genvar i = 0; i < RULES; i++) begin : g_cell
    mbre_rule_cell #(.CELL_BITS(CELL_BITS)) u_cell (
      .clk(clk), .rst(rst), .we(we[i]), .wdata(wdata),
      .in_vld(v[i]), .in_act(a[i]), .in_done(d[i]), .in_blk(b[i]),
      .mat(mat), .destroy(destroy), .want_alt(want_alt),
      .out_vld(v[i+1]), .out_act(a[i+1]), .out_done(d[i+1]), .out_blk(b[i+1]),
      .rule(rules[i*14 +: 14])
    );
  end
  assign out_vld = v[RULES];
  assign out_blk = b[RULES];
endmodule
`default_nettype wire

### design/margolus_block_rule_engine_core.sv
`default_nettype none
// Margolus block rule engine: updates one 2x2 block of a falling-sand grid.
// Input channel (in_valid/in_stall): command 1 carries a block plus three
// random picks; command 0 carries a rule_word for rule_slot and gives no
// result. Output channel (out_valid/out_stall) returns the updated block.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the material
// ids and masks; write only while the engine is idle.
// The block flows through five passes (fire-first, sand, water, gas, fire),
// each a chain of RULES_PER_MATERIAL rule cells, one cell per cycle, and
// then into the output register. One item is in flight at a time: the next
// item is taken once the previous result has been transferred.
// Reset clears every rule to invalid and loads the register defaults. While
// out_stall is high a pending result holds in the output register; no new
// item is taken while a result is pending.
module margolus_block_rule_engine_core #(
  parameter int unsigned CELL_BITS = 4,
  parameter int unsigned RULES_PER_MATERIAL = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 command,
  input  wire logic [CELL_BITS-1:0] cell_ul,
  input  wire logic [CELL_BITS-1:0] cell_ur,
  input  wire logic [CELL_BITS-1:0] cell_ll,
  input  wire logic [CELL_BITS-1:0] cell_lr,
  input  wire logic [1:0]           pick_fire_first,
  input  wire logic [1:0]           pick_gas,
  input  wire logic [1:0]           pick_fire_last,
  input  wire logic [4:0]           rule_slot,
  input  wire logic [13:0]          rule_word,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [3:0]           cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [3:0]                new_ul,
  output logic [3:0]                new_ur,
  output logic [3:0]                new_ll,
  output logic [3:0]                new_lr
);
  import mbre_pkg::*;
  localparam int unsigned R = RULES_PER_MATERIAL;
  localparam int unsigned DEPTH = NUM_MAT * R;
  localparam int unsigned CB = 4 * CELL_BITS;

  logic [3:0] wood_id, sand_id, water_id, gas_id, fire_id, destroyer_mask, chance_mask;
  logic busy;
  logic [1:0] pff, pg, pfl;
  logic [CB-1:0] blk0, b1, b2, b3, b4, b5;
  logic v1, v2, v3, v4, v5;
  logic [R*14-1:0] r_ff, r_sand, r_water, r_gas, r_fire;
  logic [R-1:0] we_sand, we_water, we_gas, we_fire;
  logic take, blk_take, wr_take, wood_p, fire_p, skip, act0, pass_en;
  logic [CELL_BITS-1:0] fid, sid, wid, gid, wdid;

  assign fid = CELL_BITS'(fire_id);
  assign sid = CELL_BITS'(sand_id);
  assign wid = CELL_BITS'(water_id);
  assign gid = CELL_BITS'(gas_id);
  assign wdid = CELL_BITS'(wood_id);

  assign in_stall = busy || out_valid;
  assign cfg_ready = 1'b1;
  assign take = in_valid && !in_stall;
  assign blk_take = take && command == CMD_BLOCK;
  assign wr_take = take && command == CMD_WRITE && 32'(rule_slot) < DEPTH;

  always_comb begin
    for (int i = 0; i < R; i++) begin
      we_sand[i] = wr_take && 32'(rule_slot) == 32'(MAT_SAND) * R + i;
      we_water[i] = wr_take && 32'(rule_slot) == 32'(MAT_WATER) * R + i;
      we_gas[i] = wr_take && 32'(rule_slot) == 32'(MAT_GAS) * R + i;
      we_fire[i] = wr_take && 32'(rule_slot) == 32'(MAT_FIRE) * R + i;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wood_id <= 4'd1; sand_id <= 4'd2; water_id <= 4'd3; gas_id <= 4'd4;
      fire_id <= 4'd5; destroyer_mask <= 4'd0; chance_mask <= 4'd12;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WOOD: wood_id <= cfg_data;
        REG_SAND: sand_id <= cfg_data;
        REG_WATER: water_id <= cfg_data;
        REG_GAS: gas_id <= cfg_data;
        REG_FIRE: fire_id <= cfg_data;
        REG_DESTROY: destroyer_mask <= cfg_data;
        REG_CHANCE: chance_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  assign blk0 = {cell_lr, cell_ll, cell_ur, cell_ul};
  always_comb begin
    wood_p = 1'b0; fire_p = 1'b0;
    for (int j = 0; j < 4; j++) begin
      if (blk0[j*CELL_BITS +: CELL_BITS] == wdid) wood_p = 1'b1;
      if (blk0[j*CELL_BITS +: CELL_BITS] == fid) fire_p = 1'b1;
    end
  end
  // mixed block only; wood without fire leaves the block alone
  assign act0 = !(cell_ul == '0 && cell_ur == '0 && cell_ll == '0 && cell_lr == '0)
             && !(cell_ul != '0 && cell_ur != '0 && cell_ll != '0 && cell_lr != '0);
  assign skip = wood_p && !fire_p;

  logic en_r;
  always_ff @(posedge clk) begin
    if (rst) busy <= 1'b0;
    else if (blk_take) busy <= 1'b1;
    else if (v5) busy <= 1'b0;
    if (blk_take) begin
      pff <= pick_fire_first;
      pg <= pick_gas;
      pfl <= pick_fire_last;
      en_r <= act0 && !skip;
    end
  end
  assign pass_en = en_r;

  // fire-first pass runs only with wood present; fire chain shares the table
  // first cell sees the pick on the port, later cells the held copy
  mbre_pass #(.CELL_BITS(CELL_BITS), .RULES(R)) u_ff (
    .clk(clk), .rst(rst), .we(we_fire), .wdata(rule_word),
    .in_vld(blk_take), .in_en(act0 && wood_p), .in_blk(blk0), .mat(fid),
    .destroy(chance_mask[MAT_FIRE] && destroyer_mask[MAT_FIRE]),
    .want_alt(chance_mask[MAT_FIRE] && (blk_take ? pick_fire_first : pff) == PICK_ALT),
    .out_vld(v1), .out_blk(b1), .rules(r_ff));
  mbre_pass #(.CELL_BITS(CELL_BITS), .RULES(R)) u_sand (
    .clk(clk), .rst(rst), .we(we_sand), .wdata(rule_word),
    .in_vld(v1), .in_en(pass_en), .in_blk(b1), .mat(sid),
    .destroy(chance_mask[MAT_SAND] && destroyer_mask[MAT_SAND]),
    .want_alt(1'b0), .out_vld(v2), .out_blk(b2), .rules(r_sand));
  mbre_pass #(.CELL_BITS(CELL_BITS), .RULES(R)) u_water (
    .clk(clk), .rst(rst), .we(we_water), .wdata(rule_word),
    .in_vld(v2), .in_en(pass_en), .in_blk(b2), .mat(wid),
    .destroy(chance_mask[MAT_WATER] && destroyer_mask[MAT_WATER]),
    .want_alt(1'b0), .out_vld(v3), .out_blk(b3), .rules(r_water));
  mbre_pass #(.CELL_BITS(CELL_BITS), .RULES(R)) u_gas (
    .clk(clk), .rst(rst), .we(we_gas), .wdata(rule_word),
    .in_vld(v3), .in_en(pass_en), .in_blk(b3), .mat(gid),
    .destroy(chance_mask[MAT_GAS] && destroyer_mask[MAT_GAS]),
    .want_alt(chance_mask[MAT_GAS] && pg == PICK_ALT),
    .out_vld(v4), .out_blk(b4), .rules(r_gas));
  mbre_pass #(.CELL_BITS(CELL_BITS), .RULES(R)) u_fire (
    .clk(clk), .rst(rst), .we(we_fire), .wdata(rule_word),
    .in_vld(v4), .in_en(pass_en), .in_blk(b4), .mat(fid),
    .destroy(chance_mask[MAT_FIRE] && destroyer_mask[MAT_FIRE]),
    .want_alt(chance_mask[MAT_FIRE] && pfl == PICK_ALT),
    .out_vld(v5), .out_blk(b5), .rules(r_fire));

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (v5) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (v5) begin
      new_ul <= 4'(b5[0 +: CELL_BITS]);
      new_ur <= 4'(b5[CELL_BITS +: CELL_BITS]);
      new_ll <= 4'(b5[2*CELL_BITS +: CELL_BITS]);
      new_lr <= 4'(b5[3*CELL_BITS +: CELL_BITS]);
    end
  end

  assert property (@(posedge clk) disable iff (rst) r_ff == r_fire)
    else $error("fire rule copies differ");
  assert property (@(posedge clk) disable iff (rst) v5 |-> busy && !out_valid)
    else $error("result arrived with no item in flight");
  assert property (@(posedge clk) disable iff (rst) blk_take |=> busy)
    else $error("busy not set after block accepted");
endmodule
`default_nettype wire
